// ===== design/assert_macros.svh =====
// Assertion helpers, included by the colorer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clock, off while reset is high.
`define CGC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define CGC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/cgc_pkg.sv =====
`timescale 1ns / 1ps

package cgc_pkg;

   localparam int COLOR_COUNT     = 12;
   localparam int BODY_SLOTS      = 1024;
   localparam int SLOTS_PER_COLOR = 4096;

   // fixed field widths
   localparam int COLOR_W = 4;
   localparam int BODY_W  = 10;
   localparam int SLOT_W  = 12;

   localparam int REAL_COLORS = COLOR_COUNT - 1;
   localparam int BODY_AW     = $clog2(BODY_SLOTS);
   localparam int COUNT_W     = $clog2(SLOTS_PER_COLOR + 1);

   localparam logic [COLOR_W-1:0] OVERFLOW_COLOR = COLOR_W'(COLOR_COUNT - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL     = COUNT_W'(SLOTS_PER_COLOR);

   typedef enum logic [1:0] {
      CMD_ADD_CONTACT,
      CMD_ADD_JOINT,
      CMD_REMOVE_CONTACT,
      CMD_REMOVE_JOINT
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BOTH_STATIC,
      STATUS_COLOR_FULL,
      STATUS_OUT_OF_RANGE
   } status_type;

   typedef logic [REAL_COLORS-1:0] color_bits_type;
   typedef logic [BODY_AW-1:0]     body_addr_type;
   typedef logic [COUNT_W-1:0]     count_type;

   typedef struct packed {
      command_type         command;
      logic [BODY_W-1:0]   body_a;
      logic [BODY_W-1:0]   body_b;
      logic                static_a;
      logic                static_b;
      logic [COLOR_W-1:0]  color_in;
      logic [SLOT_W-1:0]   slot_in;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  color_out;
      logic [SLOT_W-1:0]   slot_out;
      logic                moved;
      logic [SLOT_W-1:0]   moved_from;
      status_type          status;
   } rsp_item_type;

   // count update request from the sequencer
   typedef struct packed {
      logic                inc;
      logic                dec;
      logic                joint;
      logic [COLOR_W-1:0]  color;
   } cnt_upd_type;

endpackage

// ===== design/cgc_body_mem.sv =====
`timescale 1ns / 1ps

// Body color bit store: two registered read ports, one write port.
// A read of the address being written returns the new word.
module cgc_body_mem
   import cgc_pkg::*;
(
   input  logic           clock,
   input  body_addr_type  rd_addr_a,
   input  body_addr_type  rd_addr_b,
   output color_bits_type rd_data_a,
   output color_bits_type rd_data_b,
   input  logic           wr_en,
   input  body_addr_type  wr_addr,
   input  color_bits_type wr_data
);

   color_bits_type bits_mem [BODY_SLOTS];
   color_bits_type rd_a_ff;
   color_bits_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bits_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : bits_mem[rd_addr_a];
      rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : bits_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/cgc_color_pick.sv =====
`timescale 1ns / 1ps

// Lowest real color free for both non-static bodies, else (or when forced) overflow.
module cgc_color_pick
   import cgc_pkg::*;
(
   input  color_bits_type     word_a,
   input  color_bits_type     word_b,
   input  logic               static_a,
   input  logic               static_b,
   input  logic               contact,
   input  logic               force_overflow,
   output logic [COLOR_W-1:0] color
);

   color_bits_type busy;

   always_comb begin
      busy = (static_a ? '0 : word_a) | (static_b ? '0 : word_b);
      // contacts on a static body keep color 0 free
      if (contact && (static_a || static_b)) begin
         busy[0] = 1'b1;
      end
      color = OVERFLOW_COLOR;
      for (int i = REAL_COLORS - 1; i >= 0; i--) begin
         if (!busy[i]) begin
            color = COLOR_W'(i);
         end
      end
      if (force_overflow) begin
         color = OVERFLOW_COLOR;
      end
   end

endmodule

// ===== design/cgc_counts.sv =====
`timescale 1ns / 1ps

// Per-color fill counts for contacts and joints.
module cgc_counts
   import cgc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_joint,
   input  logic [COLOR_W-1:0] rd_color,
   output count_type          rd_count,
   input  cnt_upd_type        upd
);

   count_type contact_ff [COLOR_COUNT];
   count_type joint_ff   [COLOR_COUNT];

   always_comb begin
      rd_count = '0;
      if (32'(rd_color) < COLOR_COUNT) begin
         rd_count = rd_joint ? joint_ff[rd_color] : contact_ff[rd_color];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLOR_COUNT; i++) begin
            contact_ff[i] <= '0;
            joint_ff[i]   <= '0;
         end
      end else if (32'(upd.color) < COLOR_COUNT) begin
         if (upd.inc) begin
            if (upd.joint) begin
               joint_ff[upd.color] <= joint_ff[upd.color] + COUNT_W'(1);
            end else begin
               contact_ff[upd.color] <= contact_ff[upd.color] + COUNT_W'(1);
            end
         end else if (upd.dec) begin
            if (upd.joint) begin
               joint_ff[upd.color] <= joint_ff[upd.color] - COUNT_W'(1);
            end else begin
               contact_ff[upd.color] <= contact_ff[upd.color] - COUNT_W'(1);
            end
         end
      end
   end

endmodule

// ===== design/constraint_graph_colorer.sv =====
`timescale 1ns / 1ps

// Greedy constraint colorer. Each add item marks its non-static bodies in the
// lowest real color where neither is marked yet (contacts on a static body
// start at color 1) and takes the next slot of that color; with no free real
// color, or with force_overflow set, it lands in the overflow color. A remove
// item clears both bodies' bits and swap-removes its slot, reporting the last
// slot that moved into the hole. Each item gives exactly one result item.
// After reset the body store is cleared, one word a cycle, over all
// BODY_SLOTS (1024) words, and no item is taken meanwhile. After that each
// item runs through the look state, which reads both body words from the
// store and writes the first one back, then the done state, which writes the
// second word; that single write port sets the rate. A stalled result holds
// the block in its done state until the output register frees up.
module constraint_graph_colorer
   import cgc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_wdata
);

`include "assert_macros.svh"

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_DONE} state_type;

   state_type      state_ff, state_in;
   body_addr_type  clear_addr_ff, clear_addr_in;
   req_item_type   item_ff, item_in;
   rsp_item_type   hold_ff, hold_in;
   rsp_item_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           wb_we_ff, wb_we_in;
   color_bits_type wb_data_ff, wb_data_in;
   logic           force_overflow_ff, force_overflow_in;

   // body store
   color_bits_type rd_a, rd_b;
   logic           mem_we;
   body_addr_type  mem_waddr;
   color_bits_type mem_wdata;

   // decision in the look cycle
   logic               is_add, is_joint, both_static, same_body, ok, touch;
   logic [COLOR_W-1:0] pick_color, sel_color;
   count_type          count;
   count_type          last;
   color_bits_type     bit_mask, mask_a, mask_b, new_a, new_b;
   cnt_upd_type        upd;
   rsp_item_type       result;
   logic               out_free, accept;

   cgc_body_mem u_mem (
      .clock     (clock),
      .rd_addr_a (req_data.body_a[BODY_AW-1:0]),
      .rd_addr_b (req_data.body_b[BODY_AW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata)
   );

   cgc_color_pick u_pick (
      .word_a         (rd_a),
      .word_b         (rd_b),
      .static_a       (item_ff.static_a),
      .static_b       (item_ff.static_b),
      .contact        (!is_joint),
      .force_overflow (force_overflow_ff),
      .color          (pick_color)
   );

   cgc_counts u_counts (
      .clock    (clock),
      .reset    (reset),
      .rd_joint (is_joint),
      .rd_color (sel_color),
      .rd_count (count),
      .upd      (upd)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept    = req_valid && req_ready;

   // look cycle: pick color, check count, build new body words
   always_comb begin
      is_add      = (item_ff.command == CMD_ADD_CONTACT) || (item_ff.command == CMD_ADD_JOINT);
      is_joint    = (item_ff.command == CMD_ADD_JOINT) || (item_ff.command == CMD_REMOVE_JOINT);
      both_static = item_ff.static_a && item_ff.static_b;
      same_body   = item_ff.body_a[BODY_AW-1:0] == item_ff.body_b[BODY_AW-1:0];
      sel_color   = is_add ? pick_color : item_ff.color_in;
      last        = count - COUNT_W'(1);
      result      = '0;
      ok          = 1'b0;
      if (is_add) begin
         if (both_static) begin
            result.status = STATUS_BOTH_STATIC;
         end else if (count >= COUNT_FULL) begin
            result.color_out = sel_color;
            result.status    = STATUS_COLOR_FULL;
         end else begin
            ok               = 1'b1;
            result.color_out = sel_color;
            result.slot_out  = count[SLOT_W-1:0];
            result.status    = STATUS_OK;
         end
      end else begin
         result.color_out = item_ff.color_in;
         result.slot_out  = item_ff.slot_in;
         if ((32'(item_ff.color_in) >= COLOR_COUNT) ||
             (COUNT_W'(item_ff.slot_in) >= count)) begin
            result.status = STATUS_OUT_OF_RANGE;
         end else begin
            ok                = 1'b1;
            result.status     = STATUS_OK;
            result.moved      = COUNT_W'(item_ff.slot_in) != last;
            result.moved_from = result.moved ? last[SLOT_W-1:0] : '0;
         end
      end

      touch    = ok && (sel_color != OVERFLOW_COLOR);
      bit_mask = touch ? (color_bits_type'(1) << sel_color) : '0;
      // one body index used twice must end with both bodies' bits
      mask_a   = (!item_ff.static_a || (same_body && !item_ff.static_b)) ? bit_mask : '0;
      mask_b   = (!item_ff.static_b || (same_body && !item_ff.static_a)) ? bit_mask : '0;
      if (is_add) begin
         new_a = rd_a | mask_a;
         new_b = rd_b | mask_b;
      end else begin
         new_a = rd_a & ~bit_mask;
         new_b = rd_b & ~bit_mask;
      end

      upd.inc   = (state_ff == ST_LOOK) && ok && is_add;
      upd.dec   = (state_ff == ST_LOOK) && ok && !is_add;
      upd.joint = is_joint;
      upd.color = sel_color;
   end

   // single write port: clear sweep, first body, second body
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clear_addr_ff;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_LOOK: begin
            mem_we    = touch;
            mem_waddr = item_ff.body_a[BODY_AW-1:0];
            mem_wdata = new_a;
         end
         ST_DONE: begin
            mem_we    = wb_we_ff;
            mem_waddr = item_ff.body_b[BODY_AW-1:0];
            mem_wdata = wb_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      clear_addr_in     = clear_addr_ff;
      item_in           = item_ff;
      hold_in           = hold_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      wb_we_in          = wb_we_ff;
      wb_data_in        = wb_data_ff;
      force_overflow_in = csr_we ? csr_wdata : force_overflow_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + BODY_AW'(1);
            if (32'(clear_addr_ff) == BODY_SLOTS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hold_in    = result;
            wb_we_in   = touch;
            wb_data_in = new_b;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (accept) begin
                  item_in  = req_data;
                  state_in = ST_LOOK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clear_addr_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
         wb_we_ff          <= 1'b0;
         force_overflow_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clear_addr_ff     <= clear_addr_in;
         rsp_valid_ff      <= rsp_valid_in;
         wb_we_ff          <= wb_we_in;
         force_overflow_ff <= force_overflow_in;
      end
      item_ff    <= item_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
      wb_data_ff <= wb_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CGC_ASSERT(a_accept_to_look, accept |=> (state_ff == ST_LOOK), "accepted item did not enter look")
   `CGC_ASSERT(a_look_to_done, (state_ff == ST_LOOK) |=> (state_ff == ST_DONE), "look not followed by write-back")
   `CGC_ASSERT(a_no_write_idle, (state_ff == ST_IDLE) |-> !mem_we, "body store written while idle")
   `CGC_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> (state_ff == ST_CLEAR) && !rsp_valid, "reset did not start the clear sweep")

endmodule

// ===== tb/constraint_graph_colorer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the csr port. Keeps its own copy of the body marks,
// the per-color fill levels and the overflow switch. Compares every result
// item with the oldest expected one.
module constraint_graph_colorer_checker
   import cgc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_wdata,
   output int           mismatches,
   output int           expected_left
);

   color_bits_type body_marks [BODY_SLOTS];
   count_type      fill_level [2][COLOR_COUNT];   // [0] contacts, [1] joints
   logic           all_to_overflow;
   rsp_item_type   awaited_outcomes [$];

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Colors or removes one constraint and updates the shadow state.
   function automatic rsp_item_type color_or_remove(input req_item_type it);
      rsp_item_type res;
      int           kind;
      int           first;
      int           c;
      logic [COLOR_W-1:0] pick;
      count_type    level;
      res  = '0;
      kind = (it.command == CMD_ADD_JOINT || it.command == CMD_REMOVE_JOINT) ? 1 : 0;
      if (it.command == CMD_ADD_CONTACT || it.command == CMD_ADD_JOINT) begin
         if (it.static_a && it.static_b) begin
            res.status = STATUS_BOTH_STATIC;
         end else begin
            first = (kind == 0 && (it.static_a || it.static_b)) ? 1 : 0;
            pick  = OVERFLOW_COLOR;
            if (!all_to_overflow) begin
               // descending scan leaves the lowest free color
               for (c = REAL_COLORS - 1; c >= first; c--) begin
                  if ((it.static_a || !body_marks[it.body_a][c]) &&
                      (it.static_b || !body_marks[it.body_b][c]))
                     pick = COLOR_W'(c);
               end
            end
            level         = fill_level[kind][pick];
            res.color_out = pick;
            if (level >= SLOTS_PER_COLOR) begin
               res.status = STATUS_COLOR_FULL;
            end else begin
               if (pick != OVERFLOW_COLOR) begin
                  if (!it.static_a) body_marks[it.body_a][pick] = 1'b1;
                  if (!it.static_b) body_marks[it.body_b][pick] = 1'b1;
               end
               res.slot_out           = level[SLOT_W-1:0];
               fill_level[kind][pick] = level + COUNT_W'(1);
            end
         end
      end else begin
         res.color_out = it.color_in;
         res.slot_out  = it.slot_in;
         if (it.color_in >= COLOR_COUNT) begin
            res.status = STATUS_OUT_OF_RANGE;
         end else if (it.slot_in >= fill_level[kind][it.color_in]) begin
            res.status = STATUS_OUT_OF_RANGE;
         end else begin
            if (it.color_in != OVERFLOW_COLOR) begin
               body_marks[it.body_a][it.color_in] = 1'b0;
               body_marks[it.body_b][it.color_in] = 1'b0;
            end
            level                          = fill_level[kind][it.color_in] - COUNT_W'(1);
            fill_level[kind][it.color_in] = level;
            if (it.slot_in != level) begin
               res.moved      = 1'b1;
               res.moved_from = level[SLOT_W-1:0];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < BODY_SLOTS; i++) body_marks[i] = '0;
         for (int i = 0; i < COLOR_COUNT; i++) begin
            fill_level[0][i] = '0;
            fill_level[1][i] = '0;
         end
         all_to_overflow = 1'b0;
         awaited_outcomes.delete();
         mismatches = 0;
      end else begin
         // results first, so an early result cannot pair with a same-edge item
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: result item, expected none, actual color %0d slot %0d",
                        $time, rsp_data.color_out, rsp_data.slot_out);
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("color_out", want.color_out, rsp_data.color_out);
               compare_field("slot_out", want.slot_out, rsp_data.slot_out);
               compare_field("moved", want.moved, rsp_data.moved);
               compare_field("moved_from", want.moved_from, rsp_data.moved_from);
               compare_field("status", want.status, rsp_data.status);
            end
         end
         if (csr_we)
            all_to_overflow = csr_wdata;
         if (req_valid && req_ready)
            awaited_outcomes.push_back(color_or_remove(req_data));
      end
      expected_left = awaited_outcomes.size();
   end

endmodule

// ===== tb/constraint_graph_colorer_tb.sv =====
`timescale 1ns / 1ps

// Top of the colorer bench. Makes the items, drives reset and the csr port,
// and gives the verdict; all checking sits in the checker module.
module constraint_graph_colorer_tb;
   import cgc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 300;   // cycles the result side stalls once

   typedef enum {
      STIM_GIVEN,   // item passed in by the caller
      STIM_MIXED,   // adds, tracked removes and junk removes
      STIM_PLACE    // random adds of both kinds
   } stim_kind_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_we;
   logic         csr_wdata;
   int           mismatches;
   int           expected_left;

   // Items accepted but not answered yet, oldest first.
   req_item_type requests_in_flight [$];
   // Live constraints per kind and color, indexed by slot; rebuilt from the
   // results the block returns so that removes can name real slots.
   req_item_type bonds_by_color [2][COLOR_COUNT][$];
   // Only one random remove in flight: a second one could pick a slot the first moves.
   int           removes_in_flight = 0;

   bit sender_burst   = 1'b0;
   bit receiver_burst = 1'b0;
   bit long_hold_due  = 1'b0;

   // run statistics
   int results_seen  = 0;
   int removes_seen  = 0;
   int ok_seen       = 0;
   int static_seen   = 0;
   int full_seen     = 0;
   int range_seen    = 0;
   int overflow_seen = 0;
   int moved_seen    = 0;

   constraint_graph_colorer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   constraint_graph_colorer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop; the slowest legal run stays far below this.
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("tb: cycle limit of %0d reached", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Mostly two hot sets of bodies, at the bottom and the top of the index range,
   // so colors saturate and overflow gets used; the rest spread over the full range.
   function automatic logic [BODY_W-1:0] pool_body();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return BODY_W'($urandom_range(0, 23));
      if (roll < 9) return BODY_W'($urandom_range(BODY_SLOTS - 24, BODY_SLOTS - 1));
      return BODY_W'($urandom_range(0, BODY_SLOTS - 1));
   endfunction

   function automatic req_item_type make_request(input command_type cmd, input int a,
                                                 input int b, input bit sa, input bit sb,
                                                 input int col, input int slot);
      req_item_type it;
      it.command  = cmd;
      it.body_a   = BODY_W'(a);
      it.body_b   = BODY_W'(b);
      it.static_a = sa;
      it.static_b = sb;
      it.color_in = COLOR_W'(col);
      it.slot_in  = SLOT_W'(slot);
      return it;
   endfunction

   // Add item; color_in and slot_in are don't-care here and get random bits.
   function automatic req_item_type random_placement(input bit contacts_only);
      req_item_type it;
      it.command  = (!contacts_only && $urandom_range(0, 1)) ? CMD_ADD_JOINT : CMD_ADD_CONTACT;
      it.body_a   = pool_body();
      it.body_b   = pool_body();
      it.static_a = $urandom_range(0, 99) < 15;
      it.static_b = $urandom_range(0, 99) < 15;
      if (contacts_only && it.static_a)
         it.static_b = 1'b0;
      it.color_in = COLOR_W'($urandom_range(0, 15));
      it.slot_in  = SLOT_W'($urandom);
      return it;
   endfunction

   // About half adds; the rest removes, mostly of live constraints, some junk.
   function automatic req_item_type random_mixed_request();
      req_item_type it;
      int roll;
      int k;
      int col;
      int n;
      int slot;
      roll = $urandom_range(0, 99);
      if (removes_in_flight != 0 || roll >= 45)
         return random_placement(1'b0);
      it         = random_placement(1'b0);
      k          = $urandom_range(0, 1);
      it.command = k ? CMD_REMOVE_JOINT : CMD_REMOVE_CONTACT;
      col        = $urandom_range(0, COLOR_COUNT - 1);
      for (n = 0; n < COLOR_COUNT && bonds_by_color[k][col].size() == 0; n++)
         col = (col + 1) % COLOR_COUNT;
      if (roll < 37 && bonds_by_color[k][col].size() != 0) begin
         // last slot now and then, so the no-move path is hit too
         if ($urandom_range(0, 3) == 0)
            slot = bonds_by_color[k][col].size() - 1;
         else
            slot = $urandom_range(0, bonds_by_color[k][col].size() - 1);
         it.body_a   = bonds_by_color[k][col][slot].body_a;
         it.body_b   = bonds_by_color[k][col][slot].body_b;
         it.color_in = COLOR_W'(col);
         it.slot_in  = SLOT_W'(slot);
      end else begin
         // junk: colors past overflow, slots past the fill level, wrong kind
         it.color_in = COLOR_W'($urandom_range(0, 15));
         it.slot_in  = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 7))
                                            : SLOT_W'($urandom_range(0, 4095));
      end
      return it;
   endfunction

   // Waits the drawn gap, builds the item at the last falling edge so the
   // live table is current, then holds it until the block takes it. Valid
   // stays high after acceptance; a zero gap replaces the payload directly.
   task automatic offer(input stim_kind_type how, input req_item_type given);
      req_item_type it;
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 49) == 0)
         sender_burst = !sender_burst;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      case (how)
         STIM_GIVEN: it = given;
         STIM_MIXED: it = random_mixed_request();
         default:    it = random_placement(1'b0);
      endcase
      if (it.command == CMD_REMOVE_CONTACT || it.command == CMD_REMOVE_JOINT)
         removes_in_flight++;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops valid and waits until every accepted item has its result.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (requests_in_flight.size() != 0) @(negedge clock);
   endtask

   // Every item gives a result, so an empty in-flight list means idle.
   task automatic set_force_overflow(input logic value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Result side: random stalls per item, bursts with none, and once a long
   // hold while the sender keeps pushing.
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_due) begin
            stall         = LONG_HOLD;
            long_hold_due = 1'b0;
         end else begin
            stall = receiver_burst ? 0 : $urandom_range(0, 9);
         end
         if ($urandom_range(0, 49) == 0)
            receiver_burst = !receiver_burst;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Tracks accepted items and folds each result into the live table.
   always @(posedge clock) begin
      req_item_type done;
      int k;
      int last;
      if (!reset && rsp_valid && rsp_ready && requests_in_flight.size() != 0) begin
         done = requests_in_flight.pop_front();
         k    = (done.command == CMD_ADD_JOINT || done.command == CMD_REMOVE_JOINT) ? 1 : 0;
         results_seen++;
         case (rsp_data.status)
            STATUS_OK:          ok_seen++;
            STATUS_BOTH_STATIC: static_seen++;
            STATUS_COLOR_FULL:  full_seen++;
            default:            range_seen++;
         endcase
         if (done.command == CMD_ADD_CONTACT || done.command == CMD_ADD_JOINT) begin
            if (rsp_data.status == STATUS_OK && rsp_data.color_out < COLOR_COUNT &&
                rsp_data.slot_out == bonds_by_color[k][rsp_data.color_out].size()) begin
               bonds_by_color[k][rsp_data.color_out].push_back(done);
               if (rsp_data.color_out == OVERFLOW_COLOR)
                  overflow_seen++;
            end
         end else begin
            removes_seen++;
            removes_in_flight--;
            if (rsp_data.moved)
               moved_seen++;
            // swap-remove, same as the block
            if (rsp_data.status == STATUS_OK && done.color_in < COLOR_COUNT &&
                done.slot_in < bonds_by_color[k][done.color_in].size()) begin
               last = bonds_by_color[k][done.color_in].size() - 1;
               bonds_by_color[k][done.color_in][done.slot_in] =
                  bonds_by_color[k][done.color_in][last];
               void'(bonds_by_color[k][done.color_in].pop_back());
            end
         end
      end
      if (!reset && req_valid && req_ready)
         requests_in_flight.push_back(req_data);
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its body store for a while after reset; the first
      // item simply waits for ready.
      set_force_overflow(1'b0);

      // Directed: lowest free color, static bodies, both-static reject.
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 0, 1, 0, 0, 0, 0));
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 0, 2, 0, 0, 0, 0));
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 3, 4, 1, 1, 0, 0));
      // contact on a static body must skip color 0
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 5, 0, 1, 0, 0, 0));
      // joint with the same top body on both ends
      offer(STIM_GIVEN, make_request(CMD_ADD_JOINT, 1023, 1023, 0, 0, 0, 0));
      // joint with a static body may still take color 0 if free
      offer(STIM_GIVEN, make_request(CMD_ADD_JOINT, 0, 3, 0, 1, 0, 0));
      // removes out of range: bad color, slot past end, empty overflow
      offer(STIM_GIVEN, make_request(CMD_REMOVE_CONTACT, 0, 1, 0, 0, 15, 0));
      offer(STIM_GIVEN, make_request(CMD_REMOVE_CONTACT, 0, 1, 0, 0, 0, 4095));
      offer(STIM_GIVEN, make_request(CMD_REMOVE_JOINT, 0, 0, 0, 0, OVERFLOW_COLOR, 0));
      // remove of the only (last) slot: no move
      offer(STIM_GIVEN, make_request(CMD_REMOVE_CONTACT, 0, 1, 1, 1, 0, 0));
      // remove of slot 0 with a later slot behind it: last one moves down
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 10, 11, 0, 0, 0, 0));
      offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 12, 13, 0, 0, 0, 0));
      offer(STIM_GIVEN, make_request(CMD_REMOVE_CONTACT, 10, 11, 0, 0, 0, 0));
      // body 20 through every real color, then into overflow
      for (int i = 0; i < COLOR_COUNT; i++)
         offer(STIM_GIVEN, make_request(CMD_ADD_CONTACT, 20, 100 + i, 0, 0, 0, 0));
      // overflow remove clears no bits
      offer(STIM_GIVEN, make_request(CMD_REMOVE_CONTACT, 20, 111, 0, 0, OVERFLOW_COLOR, 0));

      // Random traffic, normal coloring.
      for (int i = 0; i < 1300; i++)
         offer(STIM_MIXED, '0);

      // Back-pressure: result side freezes while adds keep coming.
      settle();
      long_hold_due = 1'b1;
      for (int i = 0; i < 40; i++)
         offer(STIM_PLACE, '0);

      // Debug mode: all adds go to overflow.
      set_force_overflow(1'b1);
      for (int i = 0; i < 250; i++)
         offer(STIM_MIXED, '0);

      // Normal mode again.
      set_force_overflow(1'b0);
      for (int i = 0; i < 350; i++)
         offer(STIM_MIXED, '0);

      settle();
      repeat (20) @(negedge clock);

      $display("tb: %0d results checked: %0d removes, %0d with a slot move, %0d overflow adds",
               results_seen, removes_seen, moved_seen, overflow_seen);
      $display("tb: status counts ok %0d, both static %0d, color full %0d, out of range %0d",
               ok_seen, static_seen, full_seen, range_seen);
      if (mismatches == 0 && expected_left == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches, %0d results never arrived", mismatches, expected_left);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
